### rtl/coalescing_message_fifo_macros.svh
// Assertion helpers for the RTL, included by the queue module.
`ifndef COALESCING_MESSAGE_FIFO_MACROS_SVH
`define COALESCING_MESSAGE_FIFO_MACROS_SVH

// Clocked property, quiet while reset is asserted.
`define CMF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define CMF_ASSERT_NEVER(lbl, expr, msg) \
	`CMF_ASSERT(lbl, !(expr), msg)

`endif

### rtl/cmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cmf_pkg;

	localparam int TYPE_W      = 8;
	localparam int SEQ_W       = 32;
	localparam int WORD_W      = 64;
	localparam int EV_W        = 32;
	localparam int NUM_EV      = 7;
	localparam int STATUS_W    = 3;
	localparam int CMD_W       = 2;
	localparam int SIDX_W      = 4;
	localparam int DEPTH_OUT_W = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int CLASS_W     = 3;

	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_QUEUED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DROP   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NONE   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_POPPED = 3'd4;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_DONE   = 3'd6;

	localparam logic [SIDX_W-1:0] STAT_DEPTH   = 4'd0;
	localparam logic [SIDX_W-1:0] STAT_WMARK   = 4'd1;
	localparam logic [SIDX_W-1:0] STAT_PUSHED  = 4'd2;
	localparam logic [SIDX_W-1:0] STAT_POPPED  = 4'd3;
	localparam logic [SIDX_W-1:0] STAT_DROPS   = 4'd4;
	localparam logic [SIDX_W-1:0] STAT_WAKES   = 4'd5;
	localparam logic [SIDX_W-1:0] STAT_SKIPS   = 4'd6;
	localparam logic [SIDX_W-1:0] STAT_FAILS   = 4'd7;
	localparam logic [SIDX_W-1:0] STAT_SAMPLES = 4'd8;
	localparam logic [SIDX_W-1:0] STAT_TOTAL   = 4'd9;
	localparam logic [SIDX_W-1:0] STAT_MAX     = 4'd10;

	localparam int EV_PUSHED  = 0;
	localparam int EV_POPPED  = 1;
	localparam int EV_DROPS   = 2;
	localparam int EV_WAKES   = 3;
	localparam int EV_SKIPS   = 4;
	localparam int EV_FAILS   = 5;
	localparam int EV_SAMPLES = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_C = 2'd2;

	typedef struct packed {
		logic [TYPE_W-1:0] msg_type;
		logic [SEQ_W-1:0]  seq;
		logic [WORD_W-1:0] value;
		logic [WORD_W-1:0] handle;
		logic [WORD_W-1:0] stamp;
	} slot_t;

	typedef struct packed {
		logic  en;
		slot_t data;
	} slot_wr_t;

	// First matching class register wins; type zero never maps to a class.
	function automatic logic [CLASS_W-1:0] class_bit(
		input logic [TYPE_W-1:0] t,
		input logic [TYPE_W-1:0] a,
		input logic [TYPE_W-1:0] b,
		input logic [TYPE_W-1:0] c
	);
		logic [CLASS_W-1:0] r;
		r = '0;
		if (t == '0) begin
			r = '0;
		end else if (t == a) begin
			r = 3'b001;
		end else if (t == b) begin
			r = 3'b010;
		end else if (t == c) begin
			r = 3'b100;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/coalescing_message_fifo.sv
// A command taken at a clock edge is registered in v_s1 and then in done_q, which drives done.
// Throughput: one command per cycle, sustained; busy never rises. The head entry is read
// from the slot RAM every cycle at the next read pointer, with forwarding of a same-cycle write.
// Reset (arst_n low) empties the queue, clears every statistics counter, the class registers and done,
// and sets the sequence number to one. Slot RAM contents are not reset and need no clearing pass.
// Results cannot be held off: each appears on the ports for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "coalescing_message_fifo_macros.svh"

module coalescing_message_fifo #(
	parameter int unsigned QUEUE_DEPTH = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [cmf_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [cmf_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic [cmf_pkg::CMD_W-1:0]              command,
	input  wire logic [cmf_pkg::TYPE_W-1:0]             msg_type,
	input  wire logic [cmf_pkg::WORD_W-1:0]             user_value,
	input  wire logic [cmf_pkg::WORD_W-1:0]             user_handle,
	input  wire logic [cmf_pkg::WORD_W-1:0]             now_time,
	input  wire logic                                   wake_ok,
	input  wire logic [cmf_pkg::SIDX_W-1:0]             stat_index,
	output logic                                        done,
	output logic [cmf_pkg::STATUS_W-1:0]                status,
	output logic [cmf_pkg::TYPE_W-1:0]                  out_type,
	output logic [cmf_pkg::SEQ_W-1:0]                   out_seq,
	output logic [cmf_pkg::WORD_W-1:0]                  out_value,
	output logic [cmf_pkg::WORD_W-1:0]                  out_handle,
	output logic [cmf_pkg::WORD_W-1:0]                  latency,
	output logic [cmf_pkg::DEPTH_OUT_W-1:0]             queue_depth,
	output logic                                        wake_request,
	output logic [cmf_pkg::WORD_W-1:0]                  stat_value
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(QUEUE_DEPTH);

	// configuration
	logic [cmf_pkg::TYPE_W-1:0] cfg_a_q, cfg_b_q, cfg_c_q;

	// input stage
	logic                         v_s1;
	logic [cmf_pkg::CMD_W-1:0]    cmd_s1;
	logic [cmf_pkg::TYPE_W-1:0]   type_s1;
	logic [cmf_pkg::WORD_W-1:0]   value_s1;
	logic [cmf_pkg::WORD_W-1:0]   handle_s1;
	logic [cmf_pkg::WORD_W-1:0]   now_s1;
	logic                         wake_ok_s1;
	logic [cmf_pkg::SIDX_W-1:0]   sidx_s1;

	// queue and statistics state
	logic [PTR_W-1:0]           rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0]           count_q, high_q;
	logic [cmf_pkg::SEQ_W-1:0]  seq_q;
	logic [cmf_pkg::EV_W-1:0]   ev_q [cmf_pkg::NUM_EV];
	logic [cmf_pkg::WORD_W-1:0] total_q, max_q;
	logic [cmf_pkg::CLASS_W-1:0] pending_q;
	logic                       armed_q;

	// pop latency, registered in lat_s2 and folded into total and max in the cycle after the pop
	logic                       lat_v_s2;
	logic [cmf_pkg::WORD_W-1:0] lat_s2;

	// result register
	logic                         done_q;
	logic [cmf_pkg::STATUS_W-1:0] status_q;
	logic [cmf_pkg::TYPE_W-1:0]   out_type_q;
	logic [cmf_pkg::SEQ_W-1:0]    out_seq_q;
	logic [cmf_pkg::WORD_W-1:0]   out_value_q, out_handle_q, latency_q, stat_value_q;
	logic [cmf_pkg::DEPTH_OUT_W-1:0] queue_depth_q;
	logic                         wake_req_q;

	// next-state logic
	logic                         accept;
	cmf_pkg::slot_t               head;
	cmf_pkg::slot_wr_t            slot_wr;
	logic [cmf_pkg::CLASS_W-1:0]  cls, head_cls;
	logic                         push_real, drop, full, enq, deq, clr, rd_cmd;
	logic [cmf_pkg::WORD_W-1:0]   lat_raw;
	logic [cmf_pkg::WORD_W:0]     lat_sum;
	logic [cmf_pkg::WORD_W-1:0]   total_cur, max_cur;
	logic [PTR_W-1:0]             rd_adv, wr_adv, rd_ptr_d, wr_ptr_d;
	logic [CNT_W-1:0]             count_inc, count_d, high_d;
	logic [cmf_pkg::SEQ_W-1:0]    seq_d;
	logic [cmf_pkg::EV_W-1:0]     ev_d [cmf_pkg::NUM_EV];
	logic [cmf_pkg::CLASS_W-1:0]  pending_d;
	logic                         armed_d;
	logic                         wake_req_d;
	logic [cmf_pkg::STATUS_W-1:0] status_d;
	logic [cmf_pkg::WORD_W-1:0]   stat_d;
	logic [cmf_pkg::WORD_W-1:0]   depth_ext;
	logic [CNT_W:0]               occ_sum, wr_expect;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_a_q <= '0;
			cfg_b_q <= '0;
			cfg_c_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cmf_pkg::CFG_TYPE_A: cfg_a_q <= cfg_data;
				cmf_pkg::CFG_TYPE_B: cfg_b_q <= cfg_data;
				cmf_pkg::CFG_TYPE_C: cfg_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1     <= command;
		type_s1    <= msg_type;
		value_s1   <= user_value;
		handle_s1  <= user_handle;
		now_s1     <= now_time;
		wake_ok_s1 <= wake_ok;
		sidx_s1    <= stat_index;
	end

	cmf_store #(
		.DEPTH  (QUEUE_DEPTH),
		.ADDR_W (PTR_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (slot_wr),
		.wr_addr (wr_ptr_q),
		.rd_addr (rd_ptr_d),
		.rd_data (head)
	);

	assign cls      = cmf_pkg::class_bit(type_s1, cfg_a_q, cfg_b_q, cfg_c_q);
	assign head_cls = cmf_pkg::class_bit(head.msg_type, cfg_a_q, cfg_b_q, cfg_c_q);

	assign push_real = v_s1 && (cmd_s1 == cmf_pkg::CMD_PUSH) && (type_s1 != '0);
	assign drop      = push_real && ((cls & pending_q) != '0);
	assign full      = push_real && !drop && (count_q == FULL_CNT);
	assign enq       = push_real && !drop && !full;
	assign deq       = v_s1 && (cmd_s1 == cmf_pkg::CMD_POP) && (count_q != '0);
	assign clr       = v_s1 && (cmd_s1 == cmf_pkg::CMD_CLEAR);
	assign rd_cmd    = v_s1 && (cmd_s1 == cmf_pkg::CMD_READ);

	assign lat_raw = (now_s1 > head.stamp) ? (now_s1 - head.stamp) : '0;

	// Fold the previous pop's latency; reads in this cycle see the updated values.
	assign lat_sum   = {1'b0, total_q} + {1'b0, lat_s2};
	assign total_cur = !lat_v_s2 ? total_q : (lat_sum[cmf_pkg::WORD_W] ? '1 :
	                   lat_sum[cmf_pkg::WORD_W-1:0]);
	assign max_cur   = (lat_v_s2 && (lat_s2 > max_q)) ? lat_s2 : max_q;

	assign rd_adv    = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
	assign wr_adv    = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
	assign count_inc = count_q + CNT_W'(1);

	assign slot_wr.en            = enq;
	assign slot_wr.data.msg_type = type_s1;
	assign slot_wr.data.seq      = seq_q;
	assign slot_wr.data.value    = value_s1;
	assign slot_wr.data.handle   = handle_s1;
	assign slot_wr.data.stamp    = now_s1;

	always_comb begin
		rd_ptr_d   = rd_ptr_q;
		wr_ptr_d   = wr_ptr_q;
		count_d    = count_q;
		high_d     = high_q;
		seq_d      = seq_q;
		pending_d  = pending_q;
		armed_d    = armed_q;
		wake_req_d = 1'b0;
		for (int i = 0; i < cmf_pkg::NUM_EV; i++) begin
			ev_d[i] = ev_q[i];
		end

		if (clr) begin
			rd_ptr_d  = '0;
			wr_ptr_d  = '0;
			count_d   = '0;
			high_d    = '0;
			seq_d     = cmf_pkg::SEQ_W'(1);
			pending_d = '0;
			armed_d   = 1'b0;
			for (int i = 0; i < cmf_pkg::NUM_EV; i++) begin
				ev_d[i] = '0;
			end
		end else if (push_real) begin
			seq_d = seq_q + cmf_pkg::SEQ_W'(1);
			if (drop) begin
				ev_d[cmf_pkg::EV_DROPS] = ev_q[cmf_pkg::EV_DROPS] + cmf_pkg::EV_W'(1);
			end else if (enq) begin
				wr_ptr_d  = wr_adv;
				count_d   = count_inc;
				high_d    = (count_inc > high_q) ? count_inc : high_q;
				pending_d = pending_q | cls;
				ev_d[cmf_pkg::EV_PUSHED] = ev_q[cmf_pkg::EV_PUSHED] + cmf_pkg::EV_W'(1);
				if (!armed_q) begin
					wake_req_d = 1'b1;
					if (wake_ok_s1) begin
						armed_d = 1'b1;
						ev_d[cmf_pkg::EV_WAKES] = ev_q[cmf_pkg::EV_WAKES] + cmf_pkg::EV_W'(1);
					end else begin
						ev_d[cmf_pkg::EV_FAILS] = ev_q[cmf_pkg::EV_FAILS] + cmf_pkg::EV_W'(1);
					end
				end else begin
					ev_d[cmf_pkg::EV_SKIPS] = ev_q[cmf_pkg::EV_SKIPS] + cmf_pkg::EV_W'(1);
				end
			end
		end else if (deq) begin
			rd_ptr_d  = rd_adv;
			count_d   = count_q - CNT_W'(1);
			pending_d = pending_q & ~head_cls;
			if (count_q == CNT_W'(1)) begin
				armed_d = 1'b0;
			end
			ev_d[cmf_pkg::EV_POPPED]  = ev_q[cmf_pkg::EV_POPPED] + cmf_pkg::EV_W'(1);
			ev_d[cmf_pkg::EV_SAMPLES] = ev_q[cmf_pkg::EV_SAMPLES] + cmf_pkg::EV_W'(1);
		end
	end

	always_comb begin
		status_d = cmf_pkg::ST_DONE;
		if (v_s1 && (cmd_s1 == cmf_pkg::CMD_PUSH)) begin
			if (!push_real) begin
				status_d = cmf_pkg::ST_NONE;
			end else if (drop) begin
				status_d = cmf_pkg::ST_DROP;
			end else if (full) begin
				status_d = cmf_pkg::ST_FULL;
			end else begin
				status_d = cmf_pkg::ST_QUEUED;
			end
		end else if (v_s1 && (cmd_s1 == cmf_pkg::CMD_POP)) begin
			status_d = deq ? cmf_pkg::ST_POPPED : cmf_pkg::ST_EMPTY;
		end
	end

	always_comb begin
		stat_d = '0;
		if (rd_cmd) begin
			unique case (sidx_s1)
				cmf_pkg::STAT_DEPTH:   stat_d = cmf_pkg::WORD_W'(count_q);
				cmf_pkg::STAT_WMARK:   stat_d = cmf_pkg::WORD_W'(high_q);
				cmf_pkg::STAT_PUSHED:  stat_d = cmf_pkg::WORD_W'(ev_q[cmf_pkg::EV_PUSHED]);
				cmf_pkg::STAT_POPPED:  stat_d = cmf_pkg::WORD_W'(ev_q[cmf_pkg::EV_POPPED]);
				cmf_pkg::STAT_DROPS:   stat_d = cmf_pkg::WORD_W'(ev_q[cmf_pkg::EV_DROPS]);
				cmf_pkg::STAT_WAKES:   stat_d = cmf_pkg::WORD_W'(ev_q[cmf_pkg::EV_WAKES]);
				cmf_pkg::STAT_SKIPS:   stat_d = cmf_pkg::WORD_W'(ev_q[cmf_pkg::EV_SKIPS]);
				cmf_pkg::STAT_FAILS:   stat_d = cmf_pkg::WORD_W'(ev_q[cmf_pkg::EV_FAILS]);
				cmf_pkg::STAT_SAMPLES: stat_d = cmf_pkg::WORD_W'(ev_q[cmf_pkg::EV_SAMPLES]);
				cmf_pkg::STAT_TOTAL:   stat_d = total_cur;
				cmf_pkg::STAT_MAX:     stat_d = max_cur;
				default:               stat_d = '0;
			endcase
		end
	end

	assign depth_ext = cmf_pkg::WORD_W'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			count_q   <= '0;
			high_q    <= '0;
			seq_q     <= cmf_pkg::SEQ_W'(1);
			pending_q <= '0;
			armed_q   <= 1'b0;
			total_q   <= '0;
			max_q     <= '0;
			lat_v_s2  <= 1'b0;
			done_q    <= 1'b0;
			for (int i = 0; i < cmf_pkg::NUM_EV; i++) begin
				ev_q[i] <= '0;
			end
		end else begin
			rd_ptr_q  <= rd_ptr_d;
			wr_ptr_q  <= wr_ptr_d;
			count_q   <= count_d;
			high_q    <= high_d;
			seq_q     <= seq_d;
			pending_q <= pending_d;
			armed_q   <= armed_d;
			total_q   <= clr ? '0 : total_cur;
			max_q     <= clr ? '0 : max_cur;
			lat_v_s2  <= deq;
			done_q    <= v_s1;
			for (int i = 0; i < cmf_pkg::NUM_EV; i++) begin
				ev_q[i] <= ev_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		lat_s2        <= lat_raw;
		status_q      <= status_d;
		out_type_q    <= deq ? head.msg_type : '0;
		out_seq_q     <= deq ? head.seq : '0;
		out_value_q   <= deq ? head.value : '0;
		out_handle_q  <= deq ? head.handle : '0;
		latency_q     <= deq ? lat_raw : '0;
		queue_depth_q <= depth_ext[cmf_pkg::DEPTH_OUT_W-1:0];
		wake_req_q    <= wake_req_d;
		stat_value_q  <= stat_d;
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_type     = out_type_q;
	assign out_seq      = out_seq_q;
	assign out_value    = out_value_q;
	assign out_handle   = out_handle_q;
	assign latency      = latency_q;
	assign queue_depth  = queue_depth_q;
	assign wake_request = wake_req_q;
	assign stat_value   = stat_value_q;

	// write pointer must sit fill count entries past the read pointer
	assign occ_sum   = (CNT_W + 1)'(rd_ptr_q) + (CNT_W + 1)'(count_q);
	assign wr_expect = (occ_sum >= DEPTH_EXT) ? (occ_sum - DEPTH_EXT) : occ_sum;

	`CMF_ASSERT(a_one_result, v_s1 |=> done_q, "transaction in flight produced no result")
	`CMF_ASSERT_NEVER(a_count_range, count_q > FULL_CNT, "fill count beyond queue depth")
	`CMF_ASSERT(a_ptr_track, wr_ptr_q == PTR_W'(wr_expect), "pointers disagree with fill count")
	`CMF_ASSERT(a_armed_nonempty, armed_q |-> (count_q != '0), "wake armed on empty queue")
	`CMF_ASSERT(a_wake_q, done_q && wake_req_q |-> status_q == cmf_pkg::ST_QUEUED, "stray wake")

endmodule

`default_nettype wire

### rtl/cmf_store.sv
`timescale 1ns / 1ps
`default_nettype none

module cmf_store #(
	parameter int unsigned DEPTH  = 1024,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmf_pkg::slot_wr_t wr,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output cmf_pkg::slot_t        rd_data
);

	cmf_pkg::slot_t mem [DEPTH];
	cmf_pkg::slot_t rd_q;
	cmf_pkg::slot_t byp_q;
	logic           byp_sel_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
		rd_q  <= mem[rd_addr];
		byp_q <= wr.data;
	end

	// Read is old-data on a same-address write; forward the new entry instead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_sel_q <= 1'b0;
		end else begin
			byp_sel_q <= wr.en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_sel_q ? byp_q : rd_q;

endmodule

`default_nettype wire
